>>> sv/bldd_pkg.sv
// ----------------------------------------------------------------------------
// bldd_pkg
// shared types and constants of the brake light deceleration detector
// ----------------------------------------------------------------------------
package bldd_pkg;

    localparam int SPEED_W  = 16;
    localparam int MAG_W    = 15;
    localparam int FACTOR_W = 16;
    localparam int WLEN_W   = 4;
    localparam int FRAC_W   = 14;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_DATA_W = 8;

    localparam logic [MAG_W-1:0]    MAG_MAX = '1;

    localparam logic [WLEN_W-1:0]   WLEN_RST    = 4'd10;
    localparam logic [FACTOR_W-1:0] EN_FAC_RST  = 16'd15565;
    localparam logic [FACTOR_W-1:0] DIS_FAC_RST = 16'd17039;
    localparam logic [SPEED_W-1:0]  MARGIN_RST  = 16'hFFC3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH  = 2'd0,
        CFG_ENABLE_FACTOR  = 2'd1,
        CFG_DISABLE_FACTOR = 2'd2,
        CFG_DECEL_MARGIN   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DROP,
        S_APPEND,
        S_MUL_MC,
        S_MUL_SE,
        S_MUL_MG,
        S_MUL_SD,
        S_FIN,
        S_EVAL
    } t_state;

    typedef enum logic [1:0] {
        DIR_STAND = 2'b00,
        DIR_FWD   = 2'b01,
        DIR_REV   = 2'b11
    } t_dir;

endpackage

>>> sv/bldd_mul.sv
// ----------------------------------------------------------------------------
// bldd_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module bldd_mul #(
    parameter int A_W = 21,
    parameter int B_W = 17
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [A_W-1:0]    i_a,
    input  logic signed [B_W-1:0]    i_b,
    output logic signed [A_W+B_W-1:0] o_prod
);

    logic signed [A_W+B_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

>>> sv/bldd_ring.sv
// ----------------------------------------------------------------------------
// bldd_ring
// magnitude window store, one write port and one registered read port
// ----------------------------------------------------------------------------
module bldd_ring
    import bldd_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [MAG_W-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [MAG_W-1:0]  o_rd_data
);

    logic [MAG_W-1:0] r_mem [DEPTH];
    logic [MAG_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/brake_light_decel_detector_core.sv
// ----------------------------------------------------------------------------
// brake_light_decel_detector_core
// brake light control from a window average of speed magnitudes
// ----------------------------------------------------------------------------
// Each speed sample is carried from its input transfer to its result in the
// output register by a sequencer that steps through window update (when due,
// a drop of the oldest magnitude through the registered read of the window
// store, then the append) and four products formed one after another on a
// single shared multiplier, followed by the compare. The compare step holds
// while an earlier result still waits in the output register. A new sample is
// taken in the cycle after the result is registered, even while that result
// waits to be taken; the next sample is not accepted before then.
// The window store needs no clearing after reset. Result tdata bits:
// 0 brake_light, 1 turned_on, 2 turned_off.
module brake_light_decel_detector_core
    import bldd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SPEED_W-1:0]    s_axis_tdata,   // [15:0] speed
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] brake_light [1] turned_on [2] turned_off
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    localparam int HEAD_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = MAG_W + CNT_W;
    localparam int A_W    = SUM_W + 1;
    localparam int B_W    = SPEED_W + 1;
    localparam int P_W    = A_W + B_W;
    localparam int CMP_W  = P_W + FRAC_W + 1;

    t_state r_state, n_state;

    logic [WLEN_W-1:0]   r_wlen;
    logic [FACTOR_W-1:0] r_en_fac;
    logic [FACTOR_W-1:0] r_dis_fac;
    logic [SPEED_W-1:0]  r_margin;

    logic [SPEED_W-1:0]  r_speed;
    logic [MAG_W-1:0]    r_mag;
    logic [HEAD_W-1:0]   r_head;
    logic [CNT_W-1:0]    r_count;
    logic [SUM_W-1:0]    r_sum;
    t_dir                r_dir;
    logic                r_brake;

    logic signed [P_W-1:0] r_p_mc, r_p_se, r_p_mg, r_p_sd;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic signed [SPEED_W:0] w_speed_ext;
    logic signed [SPEED_W:0] w_abs;
    logic [MAG_W-1:0]        w_mag;
    t_dir                    w_dir;
    logic                    w_drop;

    logic [CNT_W:0]       w_wsum;
    logic [CNT_W:0]       w_wrap;
    logic [HEAD_W-1:0]    w_wr_addr;
    logic [MAG_W-1:0]     w_rd_data;

    logic                  w_mul_en;
    logic signed [A_W-1:0] w_mul_a;
    logic signed [B_W-1:0] w_mul_b;
    logic signed [P_W-1:0] w_prod;

    logic signed [CMP_W-1:0] w_lhs;
    logic                    w_on_cond;
    logic                    w_on_fired;
    logic                    w_brake_mid;
    logic                    w_off_fired;
    logic                    w_brake_new;
    logic                    w_out_free;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen    <= WLEN_RST;
            r_en_fac  <= EN_FAC_RST;
            r_dis_fac <= DIS_FAC_RST;
            r_margin  <= MARGIN_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WINDOW_LENGTH:  r_wlen    <= i_cfg_wdata[WLEN_W-1:0];
                CFG_ENABLE_FACTOR:  r_en_fac  <= i_cfg_wdata[FACTOR_W-1:0];
                CFG_DISABLE_FACTOR: r_dis_fac <= i_cfg_wdata[FACTOR_W-1:0];
                CFG_DECEL_MARGIN:   r_margin  <= i_cfg_wdata[SPEED_W-1:0];
            endcase
        end
    end

    // sample magnitude and direction
    assign w_speed_ext = (SPEED_W+1)'($signed(r_speed));
    assign w_abs       = w_speed_ext[SPEED_W] ? -w_speed_ext : w_speed_ext;
    assign w_mag       = w_abs[MAG_W] ? MAG_MAX : w_abs[MAG_W-1:0];
    assign w_dir       = r_speed[SPEED_W-1] ? DIR_REV :
                         ((r_speed != '0) ? DIR_FWD : DIR_STAND);
    assign w_drop      = (32'(r_count) > 32'(r_wlen)) ||
                         (32'(r_count) >= 32'(WINDOW_DEPTH));

    // append position, wrapped around the ring
    assign w_wsum    = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_count);
    assign w_wrap    = (w_wsum >= (CNT_W+1)'(WINDOW_DEPTH)) ?
                       (w_wsum - (CNT_W+1)'(WINDOW_DEPTH)) : w_wsum;
    assign w_wr_addr = w_wrap[HEAD_W-1:0];

    bldd_ring #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (HEAD_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_APPEND),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_mag),
        .i_rd_en   (r_state == S_PREP),
        .i_rd_addr (r_head),
        .o_rd_data (w_rd_data)
    );

    // operand selection for the shared multiplier
    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = A_W'(r_count);
        w_mul_b  = B_W'(r_mag);
        unique case (r_state)
            S_MUL_MC: begin
                w_mul_a = A_W'(r_count);
                w_mul_b = B_W'(r_mag);
            end
            S_MUL_SE: begin
                w_mul_a = A_W'(r_sum);
                w_mul_b = B_W'(r_en_fac);
            end
            S_MUL_MG: begin
                w_mul_a = A_W'(r_count);
                w_mul_b = B_W'($signed(r_margin));
            end
            S_MUL_SD: begin
                w_mul_a = A_W'(r_sum);
                w_mul_b = B_W'(r_dis_fac);
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    bldd_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // rule evaluation
    assign w_lhs       = CMP_W'(r_p_mc) <<< FRAC_W;
    assign w_on_cond   = (w_lhs - CMP_W'(r_p_se)) < (CMP_W'(r_p_mg) <<< FRAC_W);
    assign w_on_fired  = !r_brake && w_on_cond;
    assign w_brake_mid = r_brake || w_on_fired;
    assign w_off_fired = w_brake_mid &&
                         ((w_lhs > CMP_W'(r_p_sd)) || (r_speed == '0));
    assign w_brake_new = w_brake_mid && !w_off_fired;
    assign w_out_free  = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (s_axis_tvalid) n_state = S_PREP;
            S_PREP:   n_state = ((w_dir == r_dir) && w_drop) ? S_DROP : S_APPEND;
            S_DROP:   n_state = S_APPEND;
            S_APPEND: n_state = S_MUL_MC;
            S_MUL_MC: n_state = S_MUL_SE;
            S_MUL_SE: n_state = S_MUL_MG;
            S_MUL_MG: n_state = S_MUL_SD;
            S_MUL_SD: n_state = S_FIN;
            S_FIN:    n_state = S_EVAL;
            S_EVAL:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_dir   <= DIR_STAND;
            r_brake <= 1'b0;
        end else begin
            case (r_state)
                S_PREP: begin
                    if (w_dir != r_dir) begin
                        r_head  <= '0;
                        r_count <= '0;
                        r_sum   <= '0;
                        r_dir   <= w_dir;
                    end
                end
                S_DROP: begin
                    r_sum   <= r_sum - SUM_W'(w_rd_data);
                    r_head  <= (r_head == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    r_count <= r_count - 1'b1;
                end
                S_APPEND: begin
                    r_sum   <= r_sum + SUM_W'(r_mag);
                    r_count <= r_count + 1'b1;
                end
                S_EVAL: begin
                    if (w_out_free) begin
                        r_brake <= w_brake_new;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // sample and product registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_speed <= s_axis_tdata;
        end
        if (r_state == S_PREP) begin
            r_mag <= w_mag;
        end
        if (r_state == S_MUL_SE) begin
            r_p_mc <= w_prod;
        end
        if (r_state == S_MUL_MG) begin
            r_p_se <= w_prod;
        end
        if (r_state == S_MUL_SD) begin
            r_p_mg <= w_prod;
        end
        if (r_state == S_FIN) begin
            r_p_sd <= w_prod;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EVAL) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EVAL) && w_out_free) begin
            r_out_data <= {{(OUT_DATA_W-3){1'b0}}, w_off_fired, w_on_fired, w_brake_new};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(WINDOW_DEPTH))
        else $error("window count beyond depth");

    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_sum == '0))
        else $error("empty window with nonzero sum");

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_PREP))
        else $error("transfer not followed by window update");

    a_result_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EVAL))
        else $error("result without evaluation");

    a_on_flag_light: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[1] && !r_out_data[2]) |-> r_out_data[0])
        else $error("turn-on without light");

endmodule
